/* src/mant_pkg.sv */
// Shared constants and types for the MIDI active note tracker.
package mant_pkg;

  localparam int CHANNELS          = 16;
  localparam int NOTES_PER_CHANNEL = 128;
  localparam int COUNTER_WIDTH     = 16;

  localparam int KEY_SLOTS = 16 * 128;
  localparam int KEY_W     = $clog2(KEY_SLOTS);
  localparam int NOTE_W    = $clog2(NOTES_PER_CHANNEL);
  localparam int HELD_W    = 12;
  localparam int OUT_CNT_W = 16;

  typedef logic [COUNTER_WIDTH-1:0] hold_cnt_t;
  typedef logic [KEY_W-1:0]         key_idx_t;
  typedef logic [HELD_W-1:0]        held_t;
  typedef logic [1:0]               event_kind_t;

  localparam hold_cnt_t CNT_MAX = {COUNTER_WIDTH{1'b1}};
  localparam logic [4:0] CHAN_LIMIT = 5'(CHANNELS);

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;

  localparam event_kind_t KIND_IGNORED  = 2'd0;
  localparam event_kind_t KIND_NOTE_ON  = 2'd1;
  localparam event_kind_t KIND_NOTE_OFF = 2'd2;

endpackage

/* src/mant_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module mant_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/midi_active_note_tracker.sv */
// Top level of the MIDI active note tracker: key hold table and held-key total.
//
// Usage: each input transaction carries one MIDI channel message (status byte,
// note number, velocity). Note-on with nonzero velocity increments the hold
// count of key channel*128+note, saturating at the counter maximum; note-off,
// or note-on with velocity zero, decrements a nonzero count. The held_keys
// output counts keys with a nonzero hold count. Every message, ignored or not,
// yields exactly one result transaction.
// Flow: an accepted message reads its hold count from the table, then the
// RMW state writes the modified count back and registers the result, which
// can then be taken. No new message is taken until that read-modify-write
// through the single-read-port hold memory is done.
// A new message is taken while a result is waiting.
// Reset: after rst_n is released a clearing pass writes zero to all 2048 table
// entries, one per cycle, holding in_stall high for 2048 cycles.
// Stall: while out_stall holds a result, the next message is read and waits
// in the modify stage; further input is stalled until the result is taken.
module midi_active_note_tracker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_status_byte,
  input  logic [6:0]             in_note_number,
  input  logic [6:0]             in_note_velocity,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [11:0]            out_held_keys,
  output logic [15:0]            out_key_hold_count,
  output logic [1:0]             out_event_kind
);
  import mant_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;

  logic [1:0]   state_r, state_nxt;
  key_idx_t     clr_idx_r, clr_idx_nxt;
  key_idx_t     key_r, key_nxt;
  event_kind_t  kind_r, kind_nxt;
  held_t        total_r, total_nxt;
  logic         out_valid_r, out_valid_nxt;
  held_t        out_held_r, out_held_nxt;
  hold_cnt_t    out_cnt_r, out_cnt_nxt;
  event_kind_t  out_kind_r, out_kind_nxt;

  logic         in_accept;
  logic         rmw_done;
  event_kind_t  in_kind;
  key_idx_t     in_key;
  hold_cnt_t    rd_cnt;
  hold_cnt_t    new_cnt;
  logic         ram_we;
  key_idx_t     ram_waddr;
  hold_cnt_t    ram_wdata;
  key_idx_t     ram_raddr;

  // Decode the incoming message.
  always_comb begin
    in_kind = KIND_IGNORED;
    if ((in_status_byte[7:4] == NIB_NOTE_ON || in_status_byte[7:4] == NIB_NOTE_OFF) &&
        ({1'b0, in_status_byte[3:0]} < CHAN_LIMIT)) begin
      if (in_status_byte[7:4] == NIB_NOTE_ON && in_note_velocity != 7'd0) begin
        in_kind = KIND_NOTE_ON;
      end else begin
        in_kind = KIND_NOTE_OFF;
      end
    end
  end

  assign in_key    = {in_status_byte[3:0], in_note_number[NOTE_W-1:0]};
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign rmw_done  = (state_r == ST_RMW) && (!out_valid_r || !out_stall);

  // The read address holds the pending key while the modify stage waits,
  // so the registered read data stays valid.
  assign ram_raddr = in_accept ? in_key : key_r;

  // Modify step on the read data.
  always_comb begin
    new_cnt   = rd_cnt;
    total_nxt = total_r;
    case (kind_r)
      KIND_NOTE_ON: begin
        if (rd_cnt == '0) begin
          total_nxt = total_r + held_t'(1);
        end
        if (rd_cnt != CNT_MAX) begin
          new_cnt = rd_cnt + hold_cnt_t'(1);
        end
      end
      KIND_NOTE_OFF: begin
        if (rd_cnt != '0) begin
          new_cnt = rd_cnt - hold_cnt_t'(1);
          if (new_cnt == '0 && total_r != '0) begin
            total_nxt = total_r - held_t'(1);
          end
        end
      end
      default: begin
        new_cnt = '0;
      end
    endcase
    if (!rmw_done) begin
      total_nxt = total_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r;
    out_held_nxt  = out_held_r;
    out_cnt_nxt   = out_cnt_r;
    out_kind_nxt  = out_kind_r;
    ram_we        = 1'b0;
    ram_waddr     = key_r;
    ram_wdata     = new_cnt;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + key_idx_t'(1);
        if (clr_idx_r == key_idx_t'(KEY_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          key_nxt   = in_key;
          kind_nxt  = in_kind;
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_done) begin
          ram_we        = (kind_r != KIND_IGNORED);
          out_valid_nxt = 1'b1;
          out_held_nxt  = total_nxt;
          out_cnt_nxt   = new_cnt;
          out_kind_nxt  = kind_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    kind_r     <= kind_nxt;
    out_held_r <= out_held_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_kind_r <= out_kind_nxt;
  end

  mant_ram #(
    .WIDTH(COUNTER_WIDTH),
    .DEPTH(KEY_SLOTS)
  ) u_hold_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_cnt)
  );

  assign out_valid          = out_valid_r;
  assign out_held_keys      = out_held_r;
  assign out_key_hold_count = OUT_CNT_W'(out_cnt_r);
  assign out_event_kind     = out_kind_r;

  // A result only appears at the end of a modify step.
  a_out_from_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RMW)
    else $error("result appeared without a modify step");

  // An ignored message reports a zero hold count.
  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_IGNORED) |-> out_cnt_r == '0)
    else $error("ignored message with nonzero hold count");

  // The table is never written while an item waits for the output register.
  a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RMW && out_valid_r && out_stall) |-> !ram_we)
    else $error("table written while the result was stalled");

  // The held-key total changes only in a modify step, by at most one per item.
  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RMW) |=> $stable(total_r))
    else $error("held-key total changed outside a modify step");

  // No input is taken during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input accepted during the clearing pass");

endmodule
